// ===== src/tmc_pkg.sv =====
// Shared types and constants for the trimmed-mean clock consensus block.
`timescale 1ns / 1ps
`default_nettype none
package tmc_pkg;
    localparam int DEF_MAX_VALUES = 32;
    localparam int VAL_W          = 32;
    localparam int TRIM_W         = 4;
    localparam int USED_W         = 6;
    localparam logic [TRIM_W-1:0] TRIM_RESET = 4'd1;
    localparam logic signed [VAL_W:0] ONE_TICK = 33'sd65536;
    localparam logic signed [VAL_W:0] Q_MAX    = 33'sd2147483647;

    // Control broadcast to every cell of the sorting chain.
    typedef struct packed {
        logic ins;    // insert the broadcast value in order
        logic shift;  // move every entry one cell toward the head
        logic clr;    // drop all entries
    } t_cell_ctl;
endpackage
`default_nettype wire

// ===== src/tmc_cell.sv =====
// One cell of the sorted insertion chain: holds one value and its valid bit.
`timescale 1ns / 1ps
`default_nettype none
module tmc_cell (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire tmc_pkg::t_cell_ctl              i_ctl,
    input  wire logic signed [tmc_pkg::VAL_W-1:0] i_x,
    input  wire                                  i_prev_g,
    input  wire logic signed [tmc_pkg::VAL_W-1:0] i_prev_v,
    input  wire                                  i_prev_valid,
    input  wire logic signed [tmc_pkg::VAL_W-1:0] i_next_v,
    input  wire                                  i_next_valid,
    output logic signed [tmc_pkg::VAL_W-1:0]     o_v,
    output logic                                 o_valid,
    output logic                                 o_g
);
    import tmc_pkg::*;

    logic signed [VAL_W-1:0] r_v, n_v;
    logic r_valid, n_valid;

    // An empty cell counts as larger than any value.
    assign o_g = !r_valid || (r_v > i_x);

    // Insert, shift toward the head, or clear.
    always_comb begin
        n_v = r_v;
        n_valid = r_valid;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_v = i_next_v;
            n_valid = i_next_valid;
        end else if (i_ctl.ins && o_g) begin
            if (i_prev_g) begin
                n_v = i_prev_v;
                n_valid = i_prev_valid;
            end else begin
                n_v = i_x;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_v <= n_v;
    end

    assign o_v = r_v;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

// ===== src/tmc_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps
`default_nettype none
module tmc_div #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 6
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire [NUM_W-1:0]   i_num,
    input  wire [DEN_W-1:0]   i_den,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [CNT_W-1:0] r_cnt;
    logic r_run, r_done;
    logic [DEN_W:0] w_t;
    logic w_ge;

    // Bring down the next dividend bit and try a subtraction.
    assign w_t = {r_rem, r_quo[NUM_W-1]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_run <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? DEN_W'(w_t - {1'b0, r_den}) : w_t[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo = r_quo;
endmodule
`default_nettype wire

// ===== src/trimmed_mean_time_consensus.sv =====
// Top level: trimmed-mean clock consensus round over a sorted insertion chain.
//
//  Channel   Ports                                        Handshake
//  input     i_clock_value, i_from_neighbor, i_round_last start high, busy low
//  result    o_new_clock, o_was_updated, o_values_used,   o_result_valid, one cycle
//            o_store_overflow
//  config    i_cfg_data (trim_count)                      i_cfg_we
//
// A value beat is inserted in order into the cell chain; past the store size it is dropped.
// A last beat with too few values gives its result on the next cycle.
// Otherwise the chain drains through the adder into the divider; busy stays
// high from the accepted last beat until the divider's result is given.
// Reset is synchronous; the chain's valid bits clear, the stored values do not.
// The receiver cannot stall; each result is on the ports for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module trimmed_mean_time_consensus #(
    parameter int MAX_VALUES = tmc_pkg::DEF_MAX_VALUES
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire logic signed [tmc_pkg::VAL_W-1:0] i_clock_value,
    input  wire                                   i_from_neighbor,
    input  wire                                   i_round_last,
    input  wire                                   i_cfg_we,
    input  wire [tmc_pkg::TRIM_W-1:0]             i_cfg_data,
    output logic                                  o_result_valid,
    output logic signed [tmc_pkg::VAL_W-1:0]      o_new_clock,
    output logic                                  o_was_updated,
    output logic [tmc_pkg::USED_W-1:0]            o_values_used,
    output logic                                  o_store_overflow
);
    import tmc_pkg::*;

    localparam int CW    = $clog2(MAX_VALUES + 1);
    localparam int WW    = CW + 5;
    localparam int SUM_W = VAL_W + CW;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DRAIN = 3'b010,
        S_DIV   = 3'b100
    } t_state;

    t_state r_state;
    logic [TRIM_W-1:0] r_trim;
    logic [CW-1:0] r_count, r_k;
    logic r_ovf;
    logic signed [VAL_W-1:0] r_own;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic r_neg;

    // Chain wiring.
    t_cell_ctl w_ctl;
    logic signed [VAL_W-1:0] w_v [MAX_VALUES];
    logic w_valid [MAX_VALUES];
    logic w_g [MAX_VALUES];

    // Accepted beat and its ticked value.
    logic w_acc;
    logic signed [VAL_W:0] w_tick;
    logic signed [VAL_W-1:0] w_x;
    logic w_fits;
    logic [CW-1:0] w_cnt_after;
    logic w_ovf_after;
    logic signed [VAL_W-1:0] w_own_after;
    logic [WW-1:0] w_trim2, w_hi;
    logic w_enough;

    // Divider hookup.
    logic w_div_start, w_div_done;
    logic [SUM_W-1:0] w_div_num, w_div_quo;
    logic signed [VAL_W-1:0] w_mean;

    assign busy  = (r_state != S_IDLE);
    assign w_acc = start && !busy;

    // One tick onto a neighbor reading, saturating at the top.
    assign w_tick = {i_clock_value[VAL_W-1], i_clock_value} + ONE_TICK;
    assign w_x = !i_from_neighbor ? i_clock_value :
                 (w_tick > Q_MAX) ? Q_MAX[VAL_W-1:0] : w_tick[VAL_W-1:0];

    assign w_fits      = r_count < CW'(MAX_VALUES);
    assign w_cnt_after = w_fits ? r_count + 1'b1 : r_count;
    assign w_ovf_after = r_ovf || !w_fits;
    assign w_own_after = i_from_neighbor ? r_own : i_clock_value;
    assign w_trim2     = WW'({r_trim, 1'b0});
    assign w_enough    = WW'(w_cnt_after) > w_trim2;
    assign w_hi        = WW'(r_count) - WW'(r_trim);

    assign w_ctl.ins   = w_acc && w_fits;
    assign w_ctl.shift = (r_state == S_DRAIN);
    assign w_ctl.clr   = w_acc && i_round_last && !w_enough;

    // Sorted chain of cells, head at index 0.
    for (genvar i = 0; i < MAX_VALUES; i++) begin : g_cell
        tmc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_x          (w_x),
            .i_prev_g     ((i == 0) ? 1'b0 : w_g[(i == 0) ? 0 : i-1]),
            .i_prev_v     (w_v[(i == 0) ? 0 : i-1]),
            .i_prev_valid (w_valid[(i == 0) ? 0 : i-1]),
            .i_next_v     (w_v[(i == MAX_VALUES-1) ? i : i+1]),
            .i_next_valid ((i == MAX_VALUES-1) ? 1'b0 :
                           w_valid[(i == MAX_VALUES-1) ? i : i+1]),
            .o_v          (w_v[i]),
            .o_valid      (w_valid[i]),
            .o_g          (w_g[i])
        );
    end

    // Running sum of the kept values as they leave the head.
    always_comb begin
        n_sum = r_sum;
        if (WW'(r_k) >= WW'(r_trim) && WW'(r_k) < w_hi) begin
            n_sum = r_sum + SUM_W'(w_v[0]);
        end
    end

    assign w_div_start = (r_state == S_DRAIN) && (r_k == r_count - 1'b1);
    assign w_div_num   = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : n_sum;

    tmc_div #(
        .NUM_W (SUM_W),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (CW'(WW'(r_count) - w_trim2)),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_mean = r_neg ? VAL_W'(-w_div_quo) : w_div_quo[VAL_W-1:0];

    // Round control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_trim <= TRIM_RESET;
            r_count <= '0;
            r_ovf <= 1'b0;
            r_own <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            if (i_cfg_we) begin
                r_trim <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_own <= w_own_after;
                        r_count <= w_cnt_after;
                        r_ovf <= w_ovf_after;
                        if (i_round_last) begin
                            if (w_enough) begin
                                r_state <= S_DRAIN;
                            end else begin
                                o_result_valid <= 1'b1;
                                r_count <= '0;
                                r_ovf <= 1'b0;
                            end
                        end
                    end
                end
                S_DRAIN: begin
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_IDLE;
                        r_own <= w_mean;
                        r_count <= '0;
                        r_ovf <= 1'b0;
                        o_result_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_k <= '0;
            r_sum <= '0;
        end else if (r_state == S_DRAIN) begin
            r_k <= r_k + 1'b1;
            r_sum <= n_sum;
        end
        if (w_div_start) begin
            r_neg <= n_sum[SUM_W-1];
        end
        if (w_acc && i_round_last && !w_enough) begin
            o_new_clock <= w_own_after;
            o_was_updated <= 1'b0;
            o_values_used <= USED_W'(w_cnt_after);
            o_store_overflow <= w_ovf_after;
        end else if (r_state == S_DIV && w_div_done) begin
            o_new_clock <= w_mean;
            o_was_updated <= 1'b1;
            o_values_used <= USED_W'(r_count);
            o_store_overflow <= r_ovf;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VALUES))
        else $error("stored count beyond store size");
    a_drain_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_k < r_count))
        else $error("drain index past stored values");
    a_drain_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == S_DIV))
        else $error("divider started outside drain end");
    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_div_done) |=> (o_result_valid && o_was_updated && !busy))
        else $error("divider finish did not give a result");
`endif
endmodule
`default_nettype wire

// ===== dv/trimmed_mean_time_consensus_tb.sv =====
// Self-checking testbench for the trimmed-mean clock consensus block.
`timescale 1ns / 1ps
module trimmed_mean_time_consensus_tb;
    import tmc_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_VALUES;

    typedef struct packed {
        logic signed [VAL_W-1:0] clock_value;
        logic                    from_neighbor;
        logic                    round_last;
    } clock_beat_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_clock;
        logic                    was_updated;
        logic [USED_W-1:0]       values_used;
        logic                    store_overflow;
    } round_result_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic signed [VAL_W-1:0] i_clock_value = '0;
    logic                    i_from_neighbor = 1'b0;
    logic                    i_round_last = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [TRIM_W-1:0]       i_cfg_data = '0;
    logic                    o_result_valid;
    logic signed [VAL_W-1:0] o_new_clock;
    logic                    o_was_updated;
    logic [USED_W-1:0]       o_values_used;
    logic                    o_store_overflow;

    trimmed_mean_time_consensus dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_clock_value   (i_clock_value),
        .i_from_neighbor (i_from_neighbor),
        .i_round_last    (i_round_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_result_valid  (o_result_valid),
        .o_new_clock     (o_new_clock),
        .o_was_updated   (o_was_updated),
        .o_values_used   (o_values_used),
        .o_store_overflow(o_store_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Consensus state mirrored from the block's behavior.
    logic signed [VAL_W-1:0] round_vals [STORE_DEPTH];
    int unsigned             round_count;
    logic signed [VAL_W-1:0] own_value;
    logic                    round_dropped;
    logic [TRIM_W-1:0]       trim_setting;

    clock_beat_t   pending_beats [$];
    round_result_t expected_rounds [$];
    int            error_count;
    bit            beats_paused;
    int            burst_left;
    int            gap_left;

    // Apply one accepted beat; queue the round result when it ends the round.
    function automatic void predict_round(input clock_beat_t b);
        logic signed [VAL_W:0]   val;
        logic signed [VAL_W-1:0] sorted_vals [STORE_DEPTH];
        logic signed [VAL_W-1:0] swap;
        logic signed [63:0]      total;
        round_result_t           r;
        int unsigned             kept;
        val = {b.clock_value[VAL_W-1], b.clock_value};
        if (b.from_neighbor) begin
            val = val + ONE_TICK;
            if (val > Q_MAX) val = Q_MAX;
        end else begin
            own_value = b.clock_value;
        end
        if (round_count < STORE_DEPTH) begin
            round_vals[round_count] = val[VAL_W-1:0];
            round_count++;
        end else begin
            round_dropped = 1'b1;
        end
        if (!b.round_last) return;
        r.new_clock      = own_value;
        r.was_updated    = 1'b0;
        r.values_used    = round_count[USED_W-1:0];
        r.store_overflow = round_dropped;
        if (round_count > 2 * trim_setting) begin
            for (int i = 0; i < round_count; i++) sorted_vals[i] = round_vals[i];
            for (int i = 1; i < round_count; i++)
                for (int j = i; j > 0 && sorted_vals[j-1] > sorted_vals[j]; j--) begin
                    swap = sorted_vals[j];
                    sorted_vals[j] = sorted_vals[j-1];
                    sorted_vals[j-1] = swap;
                end
            total = 0;
            for (int i = trim_setting; i < round_count - trim_setting; i++)
                total += sorted_vals[i];
            kept = round_count - 2 * trim_setting;
            total = total / $signed({32'd0, kept});
            r.new_clock   = total[VAL_W-1:0];
            r.was_updated = 1'b1;
        end
        expected_rounds = {expected_rounds, r};
        own_value     = r.new_clock;
        round_count   = 0;
        round_dropped = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver: bursts of beats with random gaps between them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_round({i_clock_value, i_from_neighbor, i_round_last});
            end
            if (start && busy) begin
                // Hold the current beat until it is taken.
            end else if (gap_left > 0 || beats_paused || pending_beats.size() == 0) begin
                start <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                clock_beat_t b;
                b = pending_beats.pop_front();
                start           <= 1'b1;
                i_clock_value   <= b.clock_value;
                i_from_neighbor <= b.from_neighbor;
                i_round_last    <= b.round_last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor: compare each result strobe with the oldest expectation.
    always @(posedge i_clk) begin
        round_result_t want;
        if (i_rst_n && o_result_valid) begin
            if (expected_rounds.size() == 0) begin
                report_mismatch("unexpected result", o_new_clock, 0);
            end else begin
                want = expected_rounds.pop_front();
                if (o_new_clock !== want.new_clock)
                    report_mismatch("new_clock", o_new_clock, want.new_clock);
                if (o_was_updated !== want.was_updated)
                    report_mismatch("was_updated", o_was_updated, want.was_updated);
                if (o_values_used !== want.values_used)
                    report_mismatch("values_used", o_values_used, want.values_used);
                if (o_store_overflow !== want.store_overflow)
                    report_mismatch("store_overflow", o_store_overflow, want.store_overflow);
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh7FFF0000 + $urandom_range(0, 65535);
            3: return $urandom();
            default: return $signed(32'h00640000 + $urandom_range(0, 32'h0003FFFF)
                                    - 32'h00020000);
        endcase
    endfunction

    // Queue one round of n beats; the last beat carries round_last.
    task automatic queue_round(input int n, input bit with_own);
        clock_beat_t b;
        int own_at;
        own_at = with_own ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
            b.clock_value   = pick_value();
            b.from_neighbor = (i == own_at) ? 1'b0 : ($urandom_range(0, 7) != 0);
            b.round_last    = (i == n - 1);
            pending_beats = {pending_beats, b};
        end
    endtask

    // Let the queue and the block drain before touching the register.
    task automatic wait_idle();
        while (pending_beats.size() != 0 || start || expected_rounds.size() != 0)
            @(posedge i_clk);
        repeat (STORE_DEPTH + 80) @(posedge i_clk);
    endtask

    task automatic write_trim(input logic [TRIM_W-1:0] t);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= t;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        trim_setting = t;
        @(posedge i_clk);
    endtask

    initial begin
        clock_beat_t b;
        int total_beats;
        logic [TRIM_W-1:0] trims [6];
        trims = '{4'd0, 4'd15, 4'd2, 4'd1, 4'd7, 4'd3};
        round_count = 0; own_value = '0; round_dropped = 1'b0;
        trim_setting = TRIM_RESET; error_count = 0;
        beats_paused = 0; burst_left = 1; gap_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a round without an own beat at reset, field extremes, too few values.
        b = '{32'sh7FFFFFFF, 1'b1, 1'b0}; pending_beats = {pending_beats, b};
        b = '{32'sh80000000, 1'b1, 1'b0}; pending_beats = {pending_beats, b};
        b = '{32'sh7FFF8000, 1'b1, 1'b1}; pending_beats = {pending_beats, b};
        b = '{32'sh80000000, 1'b0, 1'b1}; pending_beats = {pending_beats, b};
        b = '{32'sh7FFFFFFF, 1'b0, 1'b0}; pending_beats = {pending_beats, b};
        b = '{32'sh12345678, 1'b0, 1'b0}; pending_beats = {pending_beats, b};
        b = '{-32'sd7, 1'b1, 1'b0}; pending_beats = {pending_beats, b};
        b = '{32'sh00000003, 1'b1, 1'b1}; pending_beats = {pending_beats, b};
        // Store full: the last three beats of the round are dropped, an own beat among them.
        queue_round(STORE_DEPTH + 3, 1'b1);
        pending_beats[pending_beats.size() - 2].from_neighbor = 1'b0;
        total_beats = 8 + STORE_DEPTH + 3;

        // Wait until every expected result has come, then pause the sender.
        wait_idle();
        beats_paused = 1;
        repeat (20) @(posedge i_clk);
        beats_paused = 0;

        // Random rounds under several trim settings, extremes included.
        foreach (trims[k]) begin
            write_trim(trims[k]);
            while (total_beats < (k + 1) * 1400 / 6) begin
                int n;
                case ($urandom_range(0, 9))
                    0: n = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 4);
                    1: n = $urandom_range(1, 2 * trim_setting + 1);
                    default: n = $urandom_range(1, 16);
                endcase
                queue_round(n, $urandom_range(0, 3) != 0);
                total_beats += n;
            end
        end
        wait_idle();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog well past the slowest legal run.
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
